/* src/ist_pkg.sv */
package ist_pkg;

   // field widths of the stream words
   localparam int FUNC_W = 3;
   localparam int POS_W  = 63;
   localparam int STAT_W = 3;
   localparam int AFF_W  = 7;
   localparam int REQ_W  = 136;
   localparam int RSP_W  = 200;

   // defaults for the top level parameters
   localparam int CAPACITY_DEF      = 64;
   localparam int POSITION_BITS_DEF = 63;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_OVERLAP = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd2;
   localparam logic [STAT_W-1:0] STAT_ORDER    = 3'd3;
   localparam logic [STAT_W-1:0] STAT_ZERO     = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_LAST_RD,
      ST_LAST_CMP,
      ST_DECIDE,
      ST_SCAN_EVAL,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_WRITE_A,
      ST_WRITE_B,
      ST_DONE
   } state_type;

endpackage

/* src/interval_segment_table_core.sv */
// Sorted table of non-overlapping segments (start, size) held in one RAM.
// req_ channel: one word per operation (insert-if-free, remove exact,
// append, remove overlap, find next). rsp_ channel: exactly one result
// word per request, in request order.
// An operation runs alone: a linear search reads and compares one entry
// at a time from the front of the table; remove overlap then checks each
// entry it deletes with an evaluate, read and compare step; entries are
// shifted one slot at a time (one RAM read and one RAM write per entry)
// to open or close room, then up to two entry writes follow.
// req_tready is high only while no operation is in progress; a new word
// is taken even while the previous result waits on rsp_.
// If the receiver stalls, the finished result holds in the output
// register and the next operation waits in its last state until the
// register frees up.
// Reset empties the table (entry count to zero); RAM
// contents are not cleared and are never read before being written.
module interval_segment_table_core #(
   parameter int CAPACITY      = ist_pkg::CAPACITY_DEF,
   parameter int POSITION_BITS = ist_pkg::POSITION_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // func[2:0], seg_start[65:3], seg_size[128:66], zero [135:129]
   input  logic [ist_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status[2:0], stored_size[65:3], affected[72:66], next_start[135:73],
   // next_size[198:136], zero [199]
   output logic [ist_pkg::RSP_W-1:0]  rsp_tdata
);

   localparam int PB = POSITION_BITS;
   localparam int EW = 2 * PB;
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [PB-1:0] MASK  = {PB{1'b1}};
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   ist_pkg::state_type state_ff, state_in;

   logic [ist_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [PB-1:0] off_ff, off_in, len_ff, len_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in, f_ff, f_in, d_ff, d_in, aff_ff, aff_in;
   logic [PB-1:0] prev_s_ff, prev_s_in, prev_z_ff, prev_z_in;
   logic          prev_v_ff, prev_v_in;
   logic [PB-1:0] cur_s_ff, cur_s_in, cur_z_ff, cur_z_in;
   logic          cur_v_ff, cur_v_in;
   logic          mv_up_ff, mv_up_in;
   logic [CW-1:0] mv_dst_ff, mv_dst_in, mv_gap_ff, mv_gap_in, mv_lim_ff, mv_lim_in;
   logic          wa_en_ff, wa_en_in, wb_en_ff, wb_en_in;
   logic [AW-1:0] wa_addr_ff, wa_addr_in, wb_addr_ff, wb_addr_in;
   logic [EW-1:0] wa_data_ff, wa_data_in, wb_data_ff, wb_data_in;
   logic [ist_pkg::STAT_W-1:0] status_ff, status_in;
   logic [PB-1:0] stored_ff, stored_in, nst_ff, nst_in, nsz_ff, nsz_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [ist_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [EW-1:0] mem_wdata;
   logic [CW-1:0] rd_ptr;
   logic [EW-1:0] rd_data;
   logic [PB-1:0] rd_s, rd_z;

   logic [PB:0]   prev_end, cur_end, off_end;
   logic [CW:0]   gap_end;
   logic [PB-1:0] right;
   logic          mv_done, ins_ok, len_zero, full;
   logic [PB-1:0] ins_len;

   ist_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_ptr[AW-1:0]),
      .rd_data (rd_data)
   );

   // entry fields and segment ends, one extra bit so no sum wraps
   assign rd_s     = rd_data[PB-1:0];
   assign rd_z     = rd_data[EW-1:PB];
   assign prev_end = {1'b0, prev_s_ff} + {1'b0, prev_z_ff};
   assign cur_end  = {1'b0, cur_s_ff} + {1'b0, cur_z_ff};
   assign off_end  = {1'b0, off_ff} + {1'b0, len_ff};
   assign right    = (off_end > {1'b0, MASK}) ? MASK : off_end[PB-1:0];
   assign gap_end  = {1'b0, mv_dst_ff} + {1'b0, mv_gap_ff};
   assign len_zero = (len_ff == '0);
   assign full     = (count_ff >= CAP_C);

   // insert checks: no overlap with the entry below, none starting here
   assign ins_ok  = !(prev_v_ff && prev_end > {1'b0, off_ff})
                    && !(cur_v_ff && cur_s_ff == off_ff);
   assign ins_len = (cur_v_ff && off_end > {1'b0, cur_s_ff}) ? cur_s_ff - off_ff : len_ff;

   // shift loop finished
   assign mv_done = mv_up_ff ? (mv_dst_ff <= mv_lim_ff)
                             : (mv_gap_ff == '0 || gap_end >= {1'b0, mv_lim_ff});

   assign req_tready = (state_ff == ist_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ist_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = ist_pkg::ST_DISPATCH;
         end
         ist_pkg::ST_DISPATCH: begin
            case (func_ff) inside
               ist_pkg::FUNC_INSERT, ist_pkg::FUNC_REMOVE:
                  state_in = len_zero ? ist_pkg::ST_DONE : ist_pkg::ST_SRCH_RD;
               ist_pkg::FUNC_APPEND:
                  state_in = len_zero ? ist_pkg::ST_DONE :
                             (count_ff == '0) ? ist_pkg::ST_DECIDE : ist_pkg::ST_LAST_RD;
               ist_pkg::FUNC_OVERLAP, ist_pkg::FUNC_FIND: begin
                  if ((func_ff == ist_pkg::FUNC_OVERLAP && len_zero) || count_ff == '0)
                     state_in = ist_pkg::ST_DONE;
                  else
                     state_in = ist_pkg::ST_SRCH_RD;
               end
               default: state_in = ist_pkg::ST_DONE;
            endcase
         end
         ist_pkg::ST_SRCH_RD:
            state_in = (idx_ff == count_ff) ? ist_pkg::ST_DECIDE : ist_pkg::ST_SRCH_CMP;
         ist_pkg::ST_SRCH_CMP:
            state_in = (rd_s < off_ff) ? ist_pkg::ST_SRCH_RD : ist_pkg::ST_DECIDE;
         ist_pkg::ST_LAST_RD:  state_in = ist_pkg::ST_LAST_CMP;
         ist_pkg::ST_LAST_CMP: state_in = ist_pkg::ST_DECIDE;
         ist_pkg::ST_DECIDE: begin
            case (func_ff)
               ist_pkg::FUNC_INSERT:
                  state_in = (ins_ok && !full) ? ist_pkg::ST_MOVE_RD : ist_pkg::ST_DONE;
               ist_pkg::FUNC_REMOVE:
                  state_in = (cur_v_ff && cur_s_ff == off_ff && cur_z_ff == len_ff)
                             ? ist_pkg::ST_MOVE_RD : ist_pkg::ST_DONE;
               ist_pkg::FUNC_APPEND:
                  state_in = (full || (prev_v_ff && prev_end > {1'b0, off_ff}))
                             ? ist_pkg::ST_DONE : ist_pkg::ST_WRITE_A;
               ist_pkg::FUNC_OVERLAP: begin
                  if (prev_v_ff && prev_end > {1'b0, off_ff} && prev_end > {1'b0, right})
                     state_in = full ? ist_pkg::ST_DONE : ist_pkg::ST_MOVE_RD;
                  else
                     state_in = ist_pkg::ST_SCAN_EVAL;
               end
               default: state_in = ist_pkg::ST_DONE;
            endcase
         end
         ist_pkg::ST_SCAN_EVAL: begin
            if (cur_v_ff && cur_s_ff < right && cur_end <= {1'b0, right})
               state_in = ist_pkg::ST_SCAN_RD;
            else
               state_in = ist_pkg::ST_MOVE_RD;
         end
         ist_pkg::ST_SCAN_RD:
            state_in = (idx_ff == count_ff) ? ist_pkg::ST_SCAN_EVAL : ist_pkg::ST_SCAN_CMP;
         ist_pkg::ST_SCAN_CMP: state_in = ist_pkg::ST_SCAN_EVAL;
         ist_pkg::ST_MOVE_RD:
            state_in = mv_done ? ist_pkg::ST_WRITE_A : ist_pkg::ST_MOVE_WR;
         ist_pkg::ST_MOVE_WR: state_in = ist_pkg::ST_MOVE_RD;
         ist_pkg::ST_WRITE_A: state_in = ist_pkg::ST_WRITE_B;
         ist_pkg::ST_WRITE_B: state_in = ist_pkg::ST_DONE;
         ist_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ist_pkg::ST_IDLE;
         end
         default: state_in = ist_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      func_in    = func_ff;
      off_in     = off_ff;
      len_in     = len_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      f_in       = f_ff;
      d_in       = d_ff;
      aff_in     = aff_ff;
      prev_s_in  = prev_s_ff;
      prev_z_in  = prev_z_ff;
      prev_v_in  = prev_v_ff;
      cur_s_in   = cur_s_ff;
      cur_z_in   = cur_z_ff;
      cur_v_in   = cur_v_ff;
      mv_up_in   = mv_up_ff;
      mv_dst_in  = mv_dst_ff;
      mv_gap_in  = mv_gap_ff;
      mv_lim_in  = mv_lim_ff;
      wa_en_in   = wa_en_ff;
      wa_addr_in = wa_addr_ff;
      wa_data_in = wa_data_ff;
      wb_en_in   = wb_en_ff;
      wb_addr_in = wb_addr_ff;
      wb_data_in = wb_data_ff;
      status_in  = status_ff;
      stored_in  = stored_ff;
      nst_in     = nst_ff;
      nsz_in     = nsz_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we     = 1'b0;
      mem_waddr  = mv_dst_ff[AW-1:0];
      mem_wdata  = rd_data;
      rd_ptr     = idx_ff;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ist_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               func_in = req_tdata[ist_pkg::FUNC_W-1:0];
               off_in  = req_tdata[ist_pkg::FUNC_W +: PB];
               len_in  = req_tdata[ist_pkg::FUNC_W + ist_pkg::POS_W +: PB];
            end
         end
         ist_pkg::ST_DISPATCH: begin
            status_in = ist_pkg::STAT_OK;
            stored_in = '0;
            nst_in    = '0;
            nsz_in    = '0;
            aff_in    = '0;
            d_in      = '0;
            idx_in    = '0;
            prev_v_in = 1'b0;
            cur_v_in  = 1'b0;
            wa_en_in  = 1'b0;
            wb_en_in  = 1'b0;
            if (len_zero && (func_ff == ist_pkg::FUNC_INSERT || func_ff == ist_pkg::FUNC_REMOVE
                             || func_ff == ist_pkg::FUNC_APPEND))
               status_in = ist_pkg::STAT_ZERO;
         end
         ist_pkg::ST_SRCH_RD: begin
            if (idx_ff == count_ff) f_in = idx_ff;
         end
         ist_pkg::ST_SRCH_CMP: begin
            if (rd_s < off_ff) begin
               prev_s_in = rd_s;
               prev_z_in = rd_z;
               prev_v_in = 1'b1;
               idx_in    = idx_ff + ONE_C;
            end else begin
               cur_s_in = rd_s;
               cur_z_in = rd_z;
               cur_v_in = 1'b1;
               f_in     = idx_ff;
            end
         end
         ist_pkg::ST_LAST_RD: begin
            rd_ptr = count_ff - ONE_C;
         end
         ist_pkg::ST_LAST_CMP: begin
            prev_s_in = rd_s;
            prev_z_in = rd_z;
            prev_v_in = 1'b1;
         end
         ist_pkg::ST_DECIDE: begin
            case (func_ff)
               ist_pkg::FUNC_INSERT: begin
                  if (ins_ok) begin
                     if (full) begin
                        status_in = ist_pkg::STAT_FULL;
                     end else begin
                        mv_up_in   = 1'b1;
                        mv_dst_in  = count_ff;
                        mv_lim_in  = f_ff;
                        wa_en_in   = 1'b1;
                        wa_addr_in = f_ff[AW-1:0];
                        wa_data_in = {ins_len, off_ff};
                        count_in   = count_ff + ONE_C;
                        stored_in  = ins_len;
                     end
                  end
               end
               ist_pkg::FUNC_REMOVE: begin
                  if (cur_v_ff && cur_s_ff == off_ff && cur_z_ff == len_ff) begin
                     mv_up_in  = 1'b0;
                     mv_dst_in = f_ff;
                     mv_gap_in = ONE_C;
                     mv_lim_in = count_ff;
                     count_in  = count_ff - ONE_C;
                  end else begin
                     status_in = ist_pkg::STAT_NOTFOUND;
                  end
               end
               ist_pkg::FUNC_APPEND: begin
                  if (full) begin
                     status_in = ist_pkg::STAT_FULL;
                  end else if (prev_v_ff && prev_end > {1'b0, off_ff}) begin
                     status_in = ist_pkg::STAT_ORDER;
                  end else begin
                     wa_en_in   = 1'b1;
                     wa_addr_in = count_ff[AW-1:0];
                     wa_data_in = {len_ff, off_ff};
                     count_in   = count_ff + ONE_C;
                  end
               end
               ist_pkg::FUNC_OVERLAP: begin
                  if (prev_v_ff && prev_end > {1'b0, off_ff}) begin
                     if (prev_end > {1'b0, right}) begin
                        // split the entry below in two
                        if (full) begin
                           status_in = ist_pkg::STAT_FULL;
                        end else begin
                           mv_up_in   = 1'b1;
                           mv_dst_in  = count_ff;
                           mv_lim_in  = f_ff;
                           wa_en_in   = 1'b1;
                           wa_addr_in = AW'(f_ff - ONE_C);
                           wa_data_in = {off_ff - prev_s_ff, prev_s_ff};
                           wb_en_in   = 1'b1;
                           wb_addr_in = f_ff[AW-1:0];
                           wb_data_in = {prev_end[PB-1:0] - right, right};
                           count_in   = count_ff + ONE_C;
                           aff_in     = ONE_C;
                        end
                     end else begin
                        // trim the tail of the entry below
                        wa_en_in   = 1'b1;
                        wa_addr_in = AW'(f_ff - ONE_C);
                        wa_data_in = {off_ff - prev_s_ff, prev_s_ff};
                        aff_in     = ONE_C;
                     end
                  end
               end
               ist_pkg::FUNC_FIND: begin
                  if (prev_v_ff && {1'b0, off_ff} < prev_end) begin
                     nst_in = prev_s_ff;
                     nsz_in = prev_z_ff;
                  end else if (cur_v_ff) begin
                     nst_in = cur_s_ff;
                     nsz_in = cur_z_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         ist_pkg::ST_SCAN_EVAL: begin
            if (cur_v_ff && cur_s_ff < right && cur_end <= {1'b0, right}) begin
               // entry lies wholly inside the region
               d_in   = d_ff + ONE_C;
               idx_in = idx_ff + ONE_C;
            end else begin
               if (cur_v_ff && cur_s_ff < right) begin
                  // trim the head of the last entry met
                  wb_en_in   = 1'b1;
                  wb_addr_in = f_ff[AW-1:0];
                  wb_data_in = {cur_end[PB-1:0] - right, right};
                  aff_in     = aff_ff + d_ff + ONE_C;
               end else begin
                  aff_in = aff_ff + d_ff;
               end
               mv_up_in  = 1'b0;
               mv_dst_in = f_ff;
               mv_gap_in = d_ff;
               mv_lim_in = count_ff;
               count_in  = count_ff - d_ff;
            end
         end
         ist_pkg::ST_SCAN_RD: begin
            if (idx_ff == count_ff) cur_v_in = 1'b0;
         end
         ist_pkg::ST_SCAN_CMP: begin
            cur_s_in = rd_s;
            cur_z_in = rd_z;
            cur_v_in = 1'b1;
         end
         ist_pkg::ST_MOVE_RD: begin
            rd_ptr = mv_up_ff ? mv_dst_ff - ONE_C : gap_end[CW-1:0];
         end
         ist_pkg::ST_MOVE_WR: begin
            mem_we    = 1'b1;
            mv_dst_in = mv_up_ff ? mv_dst_ff - ONE_C : mv_dst_ff + ONE_C;
         end
         ist_pkg::ST_WRITE_A: begin
            mem_we    = wa_en_ff;
            mem_waddr = wa_addr_ff;
            mem_wdata = wa_data_ff;
         end
         ist_pkg::ST_WRITE_B: begin
            mem_we    = wb_en_ff;
            mem_waddr = wb_addr_ff;
            mem_wdata = wb_data_ff;
         end
         ist_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0,
                               ist_pkg::POS_W'(nsz_ff),
                               ist_pkg::POS_W'(nst_ff),
                               ist_pkg::AFF_W'(aff_ff),
                               ist_pkg::POS_W'(stored_ff),
                               status_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ist_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      off_ff     <= off_in;
      len_ff     <= len_in;
      idx_ff     <= idx_in;
      f_ff       <= f_in;
      d_ff       <= d_in;
      aff_ff     <= aff_in;
      prev_s_ff  <= prev_s_in;
      prev_z_ff  <= prev_z_in;
      prev_v_ff  <= prev_v_in;
      cur_s_ff   <= cur_s_in;
      cur_z_ff   <= cur_z_in;
      cur_v_ff   <= cur_v_in;
      mv_up_ff   <= mv_up_in;
      mv_dst_ff  <= mv_dst_in;
      mv_gap_ff  <= mv_gap_in;
      mv_lim_ff  <= mv_lim_in;
      wa_en_ff   <= wa_en_in;
      wa_addr_ff <= wa_addr_in;
      wa_data_ff <= wa_data_in;
      wb_en_ff   <= wb_en_in;
      wb_addr_ff <= wb_addr_in;
      wb_data_ff <= wb_data_in;
      status_ff  <= status_in;
      stored_ff  <= stored_in;
      nst_ff     <= nst_in;
      nsz_ff     <= nsz_in;
      rsp_data_ff <= rsp_data_in;
   end

   // table never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("entry count above capacity");

   // ram written only by the shift loop or the final entry writes
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ist_pkg::ST_MOVE_WR || state_ff == ist_pkg::ST_WRITE_A
                  || state_ff == ist_pkg::ST_WRITE_B))
      else $error("ram write outside a write state");

   // an accepted word always starts an operation
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ist_pkg::ST_DISPATCH))
      else $error("accepted word did not start an operation");

   // a full status is only reported with a full table
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ist_pkg::ST_DONE && status_ff == ist_pkg::STAT_FULL) |-> (count_ff == CAP_C))
      else $error("table full reported below capacity");

   // the count only changes while deciding or closing a removal scan
   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff) && !$past(reset))
      |-> ($past(state_ff) == ist_pkg::ST_DECIDE || $past(state_ff) == ist_pkg::ST_SCAN_EVAL))
      else $error("entry count changed outside an update");

endmodule

/* src/ist_ram.sv */
module ist_ram #(
   parameter int WIDTH = 126,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* verif/interval_segment_table_core_tb.sv */
module interval_segment_table_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 64;
   localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct packed {
      logic [ist_pkg::STAT_W-1:0] status;
      logic [ist_pkg::POS_W-1:0]  stored_size;
      logic [ist_pkg::AFF_W-1:0]  affected;
      logic [ist_pkg::POS_W-1:0]  next_start;
      logic [ist_pkg::POS_W-1:0]  next_size;
   } seg_result_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [ist_pkg::REQ_W-1:0]  req_tdata;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [ist_pkg::RSP_W-1:0]  rsp_tdata;

   // software copy of the segment table
   logic [63:0] tbl_start [CAP+1];
   logic [63:0] tbl_size [CAP+1];
   int          tbl_count;

   seg_result_type expected_q[$];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          error_count;
   longint      cycle_count;

   interval_segment_table_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int first_at_or_after(logic [63:0] off);
      int i;
      i = 0;
      while (i < tbl_count && tbl_start[i] < off) i++;
      return i;
   endfunction

   function automatic void open_gap(int at);
      for (int k = tbl_count; k > at; k--) begin
         tbl_start[k] = tbl_start[k-1];
         tbl_size[k] = tbl_size[k-1];
      end
      tbl_count++;
   endfunction

   function automatic void close_gap(int at);
      for (int k = at; k + 1 < tbl_count; k++) begin
         tbl_start[k] = tbl_start[k+1];
         tbl_size[k] = tbl_size[k+1];
      end
      tbl_count--;
   endfunction

   // compute the result of one operation and update the table copy
   function automatic seg_result_type apply_segment_op(logic [ist_pkg::FUNC_W-1:0] func,
                                                       logic [ist_pkg::POS_W-1:0] start_in,
                                                       logic [ist_pkg::POS_W-1:0] size_in);
      seg_result_type r;
      logic [63:0] off, len, right, s, pr;
      logic        ok;
      int          i, aff;
      r = '0;
      off = {1'b0, start_in};
      len = {1'b0, size_in};
      aff = 0;
      case (func)
         ist_pkg::FUNC_INSERT: begin
            if (len == 0) r.status = ist_pkg::STAT_ZERO;
            else begin
               ok = 1'b1;
               i = first_at_or_after(off);
               if (i > 0 && tbl_start[i-1] + tbl_size[i-1] > off) ok = 1'b0;
               if (ok && i < tbl_count) begin
                  if (tbl_start[i] == off) ok = 1'b0;
                  else if (off + len > tbl_start[i]) len = tbl_start[i] - off;
               end
               if (ok) begin
                  if (tbl_count >= CAP) r.status = ist_pkg::STAT_FULL;
                  else begin
                     open_gap(i);
                     tbl_start[i] = off;
                     tbl_size[i] = len;
                     r.stored_size = len[ist_pkg::POS_W-1:0];
                  end
               end
            end
         end
         ist_pkg::FUNC_REMOVE: begin
            if (len == 0) r.status = ist_pkg::STAT_ZERO;
            else begin
               i = first_at_or_after(off);
               if (i < tbl_count && tbl_start[i] == off && tbl_size[i] == len)
                  close_gap(i);
               else r.status = ist_pkg::STAT_NOTFOUND;
            end
         end
         ist_pkg::FUNC_APPEND: begin
            if (len == 0) r.status = ist_pkg::STAT_ZERO;
            else if (tbl_count >= CAP) r.status = ist_pkg::STAT_FULL;
            else if (tbl_count > 0 &&
                     tbl_start[tbl_count-1] + tbl_size[tbl_count-1] > off)
               r.status = ist_pkg::STAT_ORDER;
            else begin
               tbl_start[tbl_count] = off;
               tbl_size[tbl_count] = len;
               tbl_count++;
            end
         end
         ist_pkg::FUNC_OVERLAP: begin
            if (len != 0 && tbl_count > 0) begin
               right = off + len;
               if (right > POS_MAX) right = POS_MAX;
               i = first_at_or_after(off);
               if (i > 0) i--;
               while (i < tbl_count && tbl_start[i] < right) begin
                  s = tbl_start[i];
                  pr = s + tbl_size[i];
                  if (s >= off && pr <= right) begin
                     close_gap(i);
                     aff++;
                  end else if (s < off && pr > off && pr <= right) begin
                     tbl_size[i] = off - s;
                     i++;
                     aff++;
                  end else if (s < off && pr > right) begin
                     if (tbl_count >= CAP) begin
                        r.status = ist_pkg::STAT_FULL;
                        aff = 0;
                        break;
                     end
                     tbl_size[i] = off - s;
                     open_gap(i + 1);
                     tbl_start[i+1] = right;
                     tbl_size[i+1] = pr - right;
                     aff++;
                     break;
                  end else if (pr > right) begin
                     tbl_start[i] = right;
                     tbl_size[i] = pr - right;
                     aff++;
                     break;
                  end else i++;
               end
            end
            r.affected = aff[ist_pkg::AFF_W-1:0];
         end
         ist_pkg::FUNC_FIND: begin
            if (tbl_count > 0) begin
               i = first_at_or_after(off);
               if (i > 0 && off < tbl_start[i-1] + tbl_size[i-1]) begin
                  r.next_start = tbl_start[i-1][ist_pkg::POS_W-1:0];
                  r.next_size = tbl_size[i-1][ist_pkg::POS_W-1:0];
               end else if (i < tbl_count) begin
                  r.next_start = tbl_start[i][ist_pkg::POS_W-1:0];
                  r.next_size = tbl_size[i][ist_pkg::POS_W-1:0];
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // send one word, predicting its result on acceptance
   task automatic send_op(logic [ist_pkg::FUNC_W-1:0] func,
                          logic [ist_pkg::POS_W-1:0] start_in,
                          logic [ist_pkg::POS_W-1:0] size_in);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, size_in, start_in, func};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q = {expected_q, apply_segment_op(func, start_in, size_in)};
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      seg_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[2:0], rsp_tdata[65:3], rsp_tdata[72:66],
                rsp_tdata[135:73], rsp_tdata[198:136]};
         if (expected_q.size() == 0) begin
            $display("%0t unexpected word: %h", $time, got);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (got.status !== want.status)
               $display("%0t status exp %0d got %0d", $time, want.status, got.status);
            if (got.stored_size !== want.stored_size)
               $display("%0t stored_size exp %0h got %0h", $time, want.stored_size,
                        got.stored_size);
            if (got.affected !== want.affected)
               $display("%0t affected exp %0d got %0d", $time, want.affected,
                        got.affected);
            if (got.next_start !== want.next_start)
               $display("%0t next_start exp %0h got %0h", $time, want.next_start,
                        got.next_start);
            if (got.next_size !== want.next_size)
               $display("%0t next_size exp %0h got %0h", $time, want.next_size,
                        got.next_size);
            if (got !== want) error_count++;
         end
      end
   end

   // stop sending and wait for every outstanding result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // random offset, mostly in a small window so segments collide
   function automatic logic [ist_pkg::POS_W-1:0] rand_pos();
      case ($urandom_range(9))
         0: return ist_pkg::POS_W'({$urandom, $urandom});
         1: return POS_MAX[ist_pkg::POS_W-1:0] - ist_pkg::POS_W'($urandom_range(300));
         default: return ist_pkg::POS_W'($urandom_range(2000));
      endcase
   endfunction

   function automatic logic [ist_pkg::POS_W-1:0] rand_len();
      case ($urandom_range(9))
         0: return ist_pkg::POS_W'({$urandom, $urandom});
         1: return '0;
         default: return ist_pkg::POS_W'($urandom_range(1, 120));
      endcase
   endfunction

   // edge cases of every operation
   task automatic test_directed();
      send_op(ist_pkg::FUNC_FIND, 0, 0);
      send_op(ist_pkg::FUNC_OVERLAP, 5, 10);
      send_op(ist_pkg::FUNC_INSERT, 100, 0);
      send_op(ist_pkg::FUNC_REMOVE, 100, 0);
      send_op(ist_pkg::FUNC_APPEND, 100, 0);
      send_op(ist_pkg::FUNC_INSERT, 100, 50);
      send_op(ist_pkg::FUNC_INSERT, 100, 5);
      send_op(ist_pkg::FUNC_INSERT, 120, 5);
      send_op(ist_pkg::FUNC_INSERT, 80, 50);
      send_op(ist_pkg::FUNC_APPEND, 140, 10);
      send_op(ist_pkg::FUNC_APPEND, 300, 20);
      send_op(ist_pkg::FUNC_REMOVE, 300, 19);
      send_op(ist_pkg::FUNC_REMOVE, 301, 20);
      send_op(ist_pkg::FUNC_FIND, 85, 0);
      send_op(ist_pkg::FUNC_FIND, 131, 7);
      send_op(ist_pkg::FUNC_FIND, 400, 0);
      send_op(ist_pkg::FUNC_OVERLAP, 90, 20);
      send_op(ist_pkg::FUNC_OVERLAP, 305, 5);
      send_op(ist_pkg::FUNC_OVERLAP, 0, 0);
      send_op(3'd5, '1, '1);
      send_op(3'd7, '1, '1);
      send_op(ist_pkg::FUNC_INSERT, POS_MAX[ist_pkg::POS_W-1:0] - 10,
              POS_MAX[ist_pkg::POS_W-1:0]);
      send_op(ist_pkg::FUNC_OVERLAP, POS_MAX[ist_pkg::POS_W-1:0] - 5,
              POS_MAX[ist_pkg::POS_W-1:0]);
      send_op(ist_pkg::FUNC_REMOVE, 300, 20);
      send_op(ist_pkg::FUNC_OVERLAP, 0, POS_MAX[ist_pkg::POS_W-1:0]);
   endtask

   // fill to capacity, then full-table cases and a refused split
   task automatic test_full_table();
      // empty whatever is left so the appends below stay in order
      while (tbl_count > 0)
         send_op(ist_pkg::FUNC_REMOVE, tbl_start[0][ist_pkg::POS_W-1:0],
                 tbl_size[0][ist_pkg::POS_W-1:0]);
      for (int k = 0; k < CAP; k++) send_op(ist_pkg::FUNC_APPEND, k * 100, 50);
      send_op(ist_pkg::FUNC_APPEND, 10000, 5);
      send_op(ist_pkg::FUNC_INSERT, 60, 10);
      send_op(ist_pkg::FUNC_OVERLAP, 110, 10);
      send_op(ist_pkg::FUNC_OVERLAP, 100, 10);
      send_op(ist_pkg::FUNC_APPEND, 1, 5);
      send_op(ist_pkg::FUNC_FIND, 6350, 0);
      wait_drained();
      send_op(ist_pkg::FUNC_OVERLAP, 0, POS_MAX[ist_pkg::POS_W-1:0]);
   endtask

   task automatic test_random(int n);
      logic [ist_pkg::FUNC_W-1:0] f;
      for (int k = 0; k < n; k++) begin
         f = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
                                      : 3'($urandom_range(0, 4));
         if (f == ist_pkg::FUNC_REMOVE && tbl_count > 0 && $urandom_range(1)) begin
            int j;
            j = $urandom_range(tbl_count - 1);
            send_op(f, tbl_start[j][ist_pkg::POS_W-1:0], tbl_size[j][ist_pkg::POS_W-1:0]);
         end else if (f == ist_pkg::FUNC_APPEND && tbl_count > 0 &&
                      $urandom_range(3) != 0) begin
            send_op(f, tbl_start[tbl_count-1][ist_pkg::POS_W-1:0] +
                    tbl_size[tbl_count-1][ist_pkg::POS_W-1:0] + $urandom_range(20),
                    $urandom_range(1, 40));
         end else if (f == ist_pkg::FUNC_OVERLAP) begin
            send_op(f, rand_pos(), ($urandom_range(3) == 0) ? rand_len()
                                                             : 63'($urandom_range(1, 60)));
         end else send_op(f, rand_pos(), rand_len());
         if (tbl_count > 56 && $urandom_range(3) == 0)
            send_op(ist_pkg::FUNC_OVERLAP, $urandom_range(500), $urandom_range(200, 2000));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      error_count = 0;
      cycle_count = 0;
      tbl_count = 0;
      send_idle_pct = 22;
      recv_idle_pct = 58;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_random(270);
      wait_drained();
      send_idle_pct = 58;
      recv_idle_pct = 22;
      test_random(270);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(200);
      wait_drained();
      repeat (300) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
src/ist_pkg.sv
src/ist_ram.sv
src/interval_segment_table_core.sv
verif/interval_segment_table_core_tb.sv
